// ----- rtl/nwps_pkg.sv -----
// shared types and constants for the nearest weak point per sector unit
package nwps_pkg;

    localparam int COORD_BITS  = 20;
    localparam int POWER_BITS  = 16;
    localparam int NUM_SECTORS = 12;
    localparam int SEC_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // difference, square and distance widths
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int DIST_BITS = SQ_BITS + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TX_X      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TX_Y      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TX_POWER  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic signed [POWER_BITS-1:0] THRESHOLD_RESET = -16'sd13819;

    typedef logic [SEC_BITS-1:0] sec_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rx_x;
        logic signed [COORD_BITS-1:0] rx_y;
        logic signed [COORD_BITS-1:0] rx_z;
        logic signed [POWER_BITS-1:0] rx_power_dbm;
        logic                         last_point;
    } in_t;

    typedef struct packed {
        sec_t                         out_sector;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic                         found;
        logic                         last_result;
    } out_t;

endpackage

// ----- rtl/nearest_weak_point_per_sector_unit.sv -----
// top level: keep test, sector binning, nearest point store and sector flush
// a last-marked point passes the four pipeline registers and then sets the flush state, which loads the first result
// throughput: one point per cycle through a four-register pipeline, except while a flush holds the input side
// a flush holds the input side while the single output register drains the store, one occupied sector
// per output transfer (a single not found transfer if none); output stalls prolong it
// reset: asynchronous active low; clears valid bits, flush state, config to defaults
module nearest_weak_point_per_sector_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // point input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  nwps_pkg::in_t                          in_data,
    // result output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output nwps_pkg::out_t                         out_data,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nwps_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [nwps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import nwps_pkg::*;

    // configuration registers
    logic signed [COORD_BITS-1:0] tx_x_reg;
    logic signed [COORD_BITS-1:0] tx_y_reg;
    logic signed [POWER_BITS-1:0] tx_pwr_reg;
    logic signed [POWER_BITS-1:0] thr_reg;

    // pipeline control
    logic pipe_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: registered input point
    in_t in1_reg;

    // stage 2: offsets, keep flag, quadrant
    logic signed [DIFF_BITS-1:0] dx2_reg, dy2_reg;
    logic [1:0]                  quad2_reg;
    logic                        keep2_reg, last2_reg;
    logic signed [COORD_BITS-1:0] px2_reg, py2_reg, pz2_reg;

    // stage 3: squares
    logic [SQ_BITS-1:0]          sqx3_reg, sqy3_reg;
    logic [1:0]                  quad3_reg;
    logic                        keep3_reg, last3_reg;
    logic signed [COORD_BITS-1:0] px3_reg, py3_reg, pz3_reg;

    // stage 4: sector and distance, feeds the store
    sec_t                        sec4_reg;
    logic [DIST_BITS-1:0]        d2_4_reg;
    logic                        keep4_reg, last4_reg;
    logic signed [COORD_BITS-1:0] px4_reg, py4_reg, pz4_reg;

    // per sector store
    logic [NUM_SECTORS-1:0]       sector_valid_reg, sector_valid_next;
    logic [DIST_BITS-1:0]         best_d_reg [NUM_SECTORS];
    logic signed [COORD_BITS-1:0] best_x_reg [NUM_SECTORS];
    logic signed [COORD_BITS-1:0] best_y_reg [NUM_SECTORS];
    logic signed [COORD_BITS-1:0] best_z_reg [NUM_SECTORS];
    logic [NUM_SECTORS-1:0]       hit;

    // flush and output
    logic                   flush_reg, flush_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;
    logic                   out_free, out_load, any_valid, load_last;
    logic [NUM_SECTORS-1:0] rest_valid;
    sec_t                   sel;

    // stage 1 combinational
    logic signed [DIFF_BITS-1:0]    dx1, dy1;
    logic signed [POWER_BITS:0]     lim1;
    logic                           keep1;
    logic [1:0]                     quad1;

    // stage 2 combinational
    logic signed [2*DIFF_BITS-1:0]  prodx2, prody2;

    // stage 3 combinational
    logic [SQ_BITS-1:0]             uu3, vv3;
    logic [SQ_BITS+1:0]             uu3x3, vv3x3;
    logic                           near_lo3, near_mid3;
    sec_t                           sec3;
    logic [SEC_BITS-1:0]            sec_base3;

    // stage 4 update enable
    logic upd_en;

    // the pipeline freezes while the store is drained
    assign pipe_en  = !flush_reg;
    assign in_stall = flush_reg;
    assign upd_en   = pipe_en && v4_reg;

    // configuration accepts a transfer in every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_x_reg   <= '0;
            tx_y_reg   <= '0;
            tx_pwr_reg <= '0;
            thr_reg    <= THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TX_X:      tx_x_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_TX_Y:      tx_y_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_TX_POWER:  tx_pwr_reg <= cfg_data[POWER_BITS-1:0];
                CFG_THRESHOLD: thr_reg    <= cfg_data[POWER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: offsets from the transmitter and the power test, done in dB
    always_comb
    begin
        dx1  = DIFF_BITS'($signed(in1_reg.rx_x)) - DIFF_BITS'(tx_x_reg);
        dy1  = DIFF_BITS'($signed(in1_reg.rx_y)) - DIFF_BITS'(tx_y_reg);
        lim1 = (POWER_BITS+1)'(tx_pwr_reg) + (POWER_BITS+1)'(thr_reg);
        // a point at the transmitter has no direction and is dropped
        keep1 = ((POWER_BITS+1)'($signed(in1_reg.rx_power_dbm)) <= lim1)
                && ((dx1 != '0) || (dy1 != '0));
        // quadrants are half open: each owns the axis where it starts
        if (dx1 > 0 && dy1 >= 0)
            quad1 = 2'd0;
        else if (dx1 <= 0 && dy1 > 0)
            quad1 = 2'd1;
        else if (dx1 < 0 && dy1 <= 0)
            quad1 = 2'd2;
        else
            quad1 = 2'd3;
    end

    // stage 2: squares of the offsets, one multiplier each
    assign prodx2 = dx2_reg * dx2_reg;
    assign prody2 = dy2_reg * dy2_reg;

    // stage 3: split the quadrant into three 30 degree sectors
    // in quadrants one and three the roles of the axes swap
    always_comb
    begin
        uu3       = quad3_reg[0] ? sqy3_reg : sqx3_reg;
        vv3       = quad3_reg[0] ? sqx3_reg : sqy3_reg;
        uu3x3     = {uu3, 1'b0} + (SQ_BITS+2)'(uu3);
        vv3x3     = {vv3, 1'b0} + (SQ_BITS+2)'(vv3);
        // tan^2(30) = 1/3 and tan^2(60) = 3
        near_lo3  = vv3x3 < (SQ_BITS+2)'(uu3);
        near_mid3 = (SQ_BITS+2)'(vv3) < uu3x3;
        sec_base3 = {quad3_reg, 1'b0} + SEC_BITS'(quad3_reg);
        if (near_lo3)
            sec3 = sec_base3;
        else if (near_mid3)
            sec3 = sec_base3 + SEC_BITS'(1);
        else
            sec3 = sec_base3 + SEC_BITS'(2);
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            in1_reg   <= in_data;

            dx2_reg   <= dx1;
            dy2_reg   <= dy1;
            quad2_reg <= quad1;
            keep2_reg <= keep1;
            last2_reg <= in1_reg.last_point;
            px2_reg   <= in1_reg.rx_x;
            py2_reg   <= in1_reg.rx_y;
            pz2_reg   <= in1_reg.rx_z;

            sqx3_reg  <= prodx2[SQ_BITS-1:0];
            sqy3_reg  <= prody2[SQ_BITS-1:0];
            quad3_reg <= quad2_reg;
            keep3_reg <= keep2_reg;
            last3_reg <= last2_reg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            pz3_reg   <= pz2_reg;

            sec4_reg  <= sec3;
            d2_4_reg  <= DIST_BITS'(sqx3_reg) + DIST_BITS'(sqy3_reg);
            keep4_reg <= keep3_reg;
            last4_reg <= last3_reg;
            px4_reg   <= px3_reg;
            py4_reg   <= py3_reg;
            pz4_reg   <= pz3_reg;
        end
    end

    // one compare lane per sector; strict less keeps the earlier point on a tie
    always_comb
    begin
        for (int i = 0; i < NUM_SECTORS; i++)
        begin
            hit[i] = upd_en && keep4_reg && (sec4_reg == SEC_BITS'(i))
                     && (!sector_valid_reg[i] || (d2_4_reg < best_d_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SECTORS; i++)
        begin
            if (hit[i])
            begin
                best_d_reg[i] <= d2_4_reg;
                best_x_reg[i] <= px4_reg;
                best_y_reg[i] <= py4_reg;
                best_z_reg[i] <= pz4_reg;
            end
        end
    end

    // flush: lowest occupied sector first, one per output transfer
    always_comb
    begin
        sel = '0;
        for (int i = NUM_SECTORS - 1; i >= 0; i--)
        begin
            if (sector_valid_reg[i])
                sel = SEC_BITS'(i);
        end
    end

    assign any_valid  = |sector_valid_reg;
    assign rest_valid = sector_valid_reg & (sector_valid_reg - 1'b1);
    assign load_last  = !any_valid || (rest_valid == '0);
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = flush_reg && out_free;

    always_comb
    begin
        sector_valid_next = sector_valid_reg;
        flush_next        = flush_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_data_next     = out_data_reg;

        if (out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.found       = any_valid;
            out_data_next.last_result = load_last;
            if (any_valid)
            begin
                out_data_next.out_sector = sel;
                out_data_next.out_x      = best_x_reg[sel];
                out_data_next.out_y      = best_y_reg[sel];
                out_data_next.out_z      = best_z_reg[sel];
                sector_valid_next        = rest_valid;
            end
            else
            begin
                // empty set: a single not found transfer
                out_data_next.out_sector = '0;
                out_data_next.out_x      = '0;
                out_data_next.out_y      = '0;
                out_data_next.out_z      = '0;
            end
            if (load_last)
                flush_next = 1'b0;
        end

        // updates happen only outside a flush, so they never meet a load
        sector_valid_next = sector_valid_next | hit;
        if (upd_en && last4_reg)
            flush_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_valid_reg <= '0;
            flush_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            sector_valid_reg <= sector_valid_next;
            flush_reg        <= flush_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a point lands in at most one sector
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit))
        else $error("point updated more than one sector");

    // a not found result is always the whole flush
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> out_data.last_result)
        else $error("not found result without last_result");

    // the final transfer of a flush leaves the store empty and the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && load_last) |=> (sector_valid_reg == '0) && !flush_reg)
        else $error("store not empty after flush");

    // the pipeline never touches the store during a flush
    assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (hit == '0))
        else $error("store updated during flush");

endmodule

// ----- tb/tb.sv -----
// testbench for the nearest weak point per sector unit
`timescale 1ns / 1ps

module tb;
    import nwps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;   // idle margin added after the last expected result has arrived

    // keeps its own copy of the transmitter settings and the per-sector store,
    // and works out which results each accepted point should produce
    class sector_nearest_tracker;
        longint tx_x;
        longint tx_y;
        longint tx_pwr;
        longint thresh;
        bit     occupied [NUM_SECTORS];
        longint best_d2 [NUM_SECTORS];
        logic signed [COORD_BITS-1:0] best_x [NUM_SECTORS];
        logic signed [COORD_BITS-1:0] best_y [NUM_SECTORS];
        logic signed [COORD_BITS-1:0] best_z [NUM_SECTORS];
        out_t   pending_results [$];
        int     n_points;
        int     n_kept;
        int     n_flushes;
        int     n_empty;
        int     n_results;
        int     n_fail;

        function new();
            tx_x = 0;
            tx_y = 0;
            tx_pwr = 0;
            thresh = longint'(THRESHOLD_RESET);
            foreach (occupied[i])
                occupied[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_TX_X:      tx_x = longint'($signed(data[COORD_BITS-1:0]));
                CFG_TX_Y:      tx_y = longint'($signed(data[COORD_BITS-1:0]));
                CFG_TX_POWER:  tx_pwr = longint'($signed(data[POWER_BITS-1:0]));
                CFG_THRESHOLD: thresh = longint'($signed(data[POWER_BITS-1:0]));
                default: ;
            endcase
        endfunction

        // half-open 30 degree sectors, compared on squares to stay exact
        function int sector_of(longint dx, longint dy);
            int quad;
            longint u;
            longint v;
            longint uu;
            longint vv;
            if (dx > 0 && dy >= 0) begin
                quad = 0; u = dx; v = dy;
            end else if (dx <= 0 && dy > 0) begin
                quad = 1; u = dy; v = -dx;
            end else if (dx < 0 && dy <= 0) begin
                quad = 2; u = -dx; v = -dy;
            end else begin
                quad = 3; u = -dy; v = dx;
            end
            uu = u * u;
            vv = v * v;
            if (3 * vv < uu)
                return quad * 3;
            if (vv < 3 * uu)
                return quad * 3 + 1;
            return quad * 3 + 2;
        endfunction

        function void take_point(in_t p);
            longint dx;
            longint dy;
            longint pw;
            longint d2;
            int     s;
            out_t   r;
            out_t   flush [$];
            n_points++;
            dx = longint'(p.rx_x) - tx_x;
            dy = longint'(p.rx_y) - tx_y;
            pw = longint'(p.rx_power_dbm);
            // weak enough and not sitting on the transmitter
            if (pw <= tx_pwr + thresh && !(dx == 0 && dy == 0)) begin
                n_kept++;
                s = sector_of(dx, dy);
                d2 = dx * dx + dy * dy;
                // strict compare: an earlier point wins a tie
                if (!occupied[s] || d2 < best_d2[s]) begin
                    occupied[s] = 1'b1;
                    best_d2[s] = d2;
                    best_x[s] = p.rx_x;
                    best_y[s] = p.rx_y;
                    best_z[s] = p.rx_z;
                end
            end
            if (!p.last_point)
                return;
            n_flushes++;
            for (int i = 0; i < NUM_SECTORS; i++) begin
                if (occupied[i]) begin
                    r.out_sector = sec_t'(i);
                    r.out_x = best_x[i];
                    r.out_y = best_y[i];
                    r.out_z = best_z[i];
                    r.found = 1'b1;
                    r.last_result = 1'b0;
                    flush.push_back(r);
                    occupied[i] = 1'b0;
                end
            end
            if (flush.size() == 0) begin
                // nothing stored: a single not-found result
                n_empty++;
                r = '0;
                r.last_result = 1'b1;
                flush.push_back(r);
            end else begin
                flush[flush.size() - 1].last_result = 1'b1;
            end
            foreach (flush[i])
                pending_results.push_back(flush[i]);
        endfunction

        function void check_result(out_t r);
            out_t e;
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no expectation: sector %0d x %0d y %0d z %0d",
                       r.out_sector, r.out_x, r.out_y, r.out_z);
                n_fail++;
                return;
            end
            e = pending_results.pop_front();
            if (r.out_sector !== e.out_sector) begin
                $error("out_sector: expected %0d, got %0d", e.out_sector, r.out_sector);
                n_fail++;
            end
            if (r.out_x !== e.out_x) begin
                $error("out_x: expected %0d, got %0d", e.out_x, r.out_x);
                n_fail++;
            end
            if (r.out_y !== e.out_y) begin
                $error("out_y: expected %0d, got %0d", e.out_y, r.out_y);
                n_fail++;
            end
            if (r.out_z !== e.out_z) begin
                $error("out_z: expected %0d, got %0d", e.out_z, r.out_z);
                n_fail++;
            end
            if (r.found !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, r.found);
                n_fail++;
            end
            if (r.last_result !== e.last_result) begin
                $error("last_result: expected %0d, got %0d", e.last_result, r.last_result);
                n_fail++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_TX_X;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    sector_nearest_tracker tracker = new();

    // idle percentages for the sender and the receiver, changed per phase
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    // last random point, reused now and then to hit distance ties
    in_t prev_pt = '0;
    bit  have_prev = 1'b0;

    nearest_weak_point_per_sector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    // receiver side: random back-pressure, decided once per falling edge
    always @(negedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // every result transfer is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_data);
    end

    // runaway guard
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // one point transfer; starts and ends on a falling edge, leaves valid high
    // so back-to-back points need no second assignment in the same step
    task automatic send_point(in_t p);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_point(p);
        @(negedge clk);
    endtask

    task automatic send_xy(longint x, longint y, longint z, longint pw, bit last);
        in_t p;
        p.rx_x = COORD_BITS'(x);
        p.rx_y = COORD_BITS'(y);
        p.rx_z = COORD_BITS'(z);
        p.rx_power_dbm = POWER_BITS'(pw);
        p.last_point = last;
        send_point(p);
    endtask

    // one register write transfer; the upper data bits carry junk on purpose
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, longint value);
        logic [CFG_DATA_BITS-1:0] d;
        d = $urandom();
        if (idx == CFG_TX_X || idx == CFG_TX_Y)
            d[COORD_BITS-1:0] = COORD_BITS'(value);
        else
            d[POWER_BITS-1:0] = POWER_BITS'(value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, d);
        @(negedge clk);
    endtask

    // only called with nothing in flight
    task automatic program_transmitter(longint x, longint y, longint pwr, longint thr);
        cfg_write(CFG_TX_X, x);
        cfg_write(CFG_TX_Y, y);
        cfg_write(CFG_TX_POWER, pwr);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    // hold off the sender until every expected result has arrived
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // random point: mostly near the transmitter so sectors fill and compete,
    // some on the axes, on the transmitter, or anywhere on the grid
    function automatic in_t make_point();
        in_t    p;
        longint dx;
        longint dy;
        longint lim;
        longint pw;
        int     sel;
        sel = $urandom_range(99);
        dx = 0;
        dy = 0;
        if (sel < 10 && have_prev) begin
            p.rx_x = prev_pt.rx_x;
            p.rx_y = prev_pt.rx_y;
        end else if (sel >= 88) begin
            p.rx_x = COORD_BITS'($urandom());
            p.rx_y = COORD_BITS'($urandom());
        end else begin
            if (sel < 55) begin
                dx = longint'($urandom_range(128)) - 64;
                dy = longint'($urandom_range(128)) - 64;
            end else if (sel < 75) begin
                dx = longint'($urandom_range(4000)) - 2000;
                dy = longint'($urandom_range(4000)) - 2000;
            end else if (sel < 85) begin
                dx = longint'($urandom_range(1000)) - 500;
                if ($urandom_range(1)) begin
                    dy = dx;
                    dx = 0;
                end
            end
            // wraps on the grid edge just as the coordinate field does
            p.rx_x = COORD_BITS'(tracker.tx_x + dx);
            p.rx_y = COORD_BITS'(tracker.tx_y + dy);
        end
        p.rx_z = COORD_BITS'($urandom());
        lim = tracker.tx_pwr + tracker.thresh;
        sel = $urandom_range(99);
        if (sel < 50)
            pw = lim - longint'($urandom_range(400));
        else if (sel < 70)
            pw = lim + longint'($urandom_range(1));
        else
            pw = longint'($signed(16'($urandom())));
        if (pw < -32768)
            pw = -32768;
        if (pw > 32767)
            pw = 32767;
        p.rx_power_dbm = POWER_BITS'(pw);
        p.last_point = 1'b0;
        prev_pt = p;
        have_prev = 1'b1;
        return p;
    endfunction

    initial
    begin
        int   send_pct [5];
        int   recv_pct [5];
        in_t  p;
        send_pct = '{0, 51, 0, 24, 0};
        recv_pct = '{0, 0, 51, 24, 0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: reset settings, transmitter at origin, offset -13819
        send_xy(0, 0, 5, -20000, 1'b1);         // on the transmitter, empty flush
        send_xy(100, 0, 1, -13819, 1'b0);       // exactly at threshold, +x edge
        send_xy(100, 0, 2, -14000, 1'b0);       // same distance, earlier stays
        send_xy(0, 100, 3, -13820, 1'b0);       // +y edge
        send_xy(-100, 0, 4, -20000, 1'b0);      // -x edge
        send_xy(0, -100, 5, -32768, 1'b0);      // -y edge
        send_xy(0, 1, 6, -13818, 1'b0);         // one step too strong, dropped
        send_xy(0, -50, 7, -15000, 1'b1);       // nearer, replaces; flush

        // one point in the middle of each sector: full twelve-result flush
        send_xy(966, 259, 10, -30000, 1'b0);
        send_xy(707, 707, 11, -30000, 1'b0);
        send_xy(259, 966, 12, -30000, 1'b0);
        send_xy(-259, 966, 13, -30000, 1'b0);
        send_xy(-707, 707, 14, -30000, 1'b0);
        send_xy(-966, 259, 15, -30000, 1'b0);
        send_xy(-966, -259, 16, -30000, 1'b0);
        send_xy(-707, -707, 17, -30000, 1'b0);
        send_xy(-259, -966, 18, -30000, 1'b0);
        send_xy(259, -966, 19, -30000, 1'b0);
        send_xy(707, -707, 20, -30000, 1'b0);
        send_xy(966, -259, 21, -30000, 1'b1);
        settle();

        // grid corners, largest power and a positive offset: all pass the power test
        program_transmitter(524287, -524288, 32767, 32767);
        send_xy(-524288, 524287, -524288, 32767, 1'b0);
        send_xy(524287, -524288, 524287, -32768, 1'b1);
        settle();

        // lowest power and offset: nothing can pass
        program_transmitter(-524288, 524287, -32768, -32768);
        send_xy(524287, -524288, 0, -32768, 1'b1);
        settle();

        // random phases, each with its own settings and idling pattern
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: program_transmitter(0, 0, 0, longint'(THRESHOLD_RESET));
                1: program_transmitter(524287, 524287,
                                       longint'($signed(16'($urandom()))), 0);
                2: program_transmitter(-524288, -524288, 32767, -32768);
                3: program_transmitter(longint'($signed(20'($urandom()))),
                                       longint'($signed(20'($urandom()))),
                                       longint'($signed(16'($urandom()))),
                                       -longint'($urandom_range(32768)));
                default: program_transmitter(longint'($signed(20'($urandom()))),
                                             longint'($signed(20'($urandom()))),
                                             longint'($signed(16'($urandom()))),
                                             longint'($signed(16'($urandom()))));
            endcase
            send_idle_pct = send_pct[ph];
            stall_pct = recv_pct[ph];
            have_prev = 1'b0;
            for (int n = 0; n < 22; n++) begin
                p = make_point();
                p.last_point = (n == 21) || ($urandom_range(7) == 0);
                send_point(p);
                // now and then let the flush drain before going on
                if (p.last_point && n != 21 && $urandom_range(3) == 0)
                    settle();
            end
            settle();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        settle();

        foreach (tracker.pending_results[i]) begin
            $error("missing result: sector %0d found %0d",
                   tracker.pending_results[i].out_sector, tracker.pending_results[i].found);
            tracker.n_fail++;
        end

        $display("points sent %0d (kept %0d), flushes %0d (empty %0d)",
                 tracker.n_points, tracker.n_kept, tracker.n_flushes, tracker.n_empty);
        $display("results checked %0d over %0d cycles, mismatches %0d",
                 tracker.n_results, cycle_count, tracker.n_fail);
        if (tracker.n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
